// ===== design/cep_pkg.sv =====
// Shared types and constants for the Chebyshev ephemeris position block.
package cep_pkg;

   localparam int RECORD_WORDS = 1024;
   localparam int RECORD_COUNT = 16;
   localparam int BODY_COUNT   = 13;
   localparam int MAX_TERMS    = 16;
   localparam int AXES         = 3;

   localparam int STORE_DEPTH = RECORD_WORDS * RECORD_COUNT;
   localparam int MEM_AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int REC_W       = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
   localparam int BODY_AW     = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;
   // largest word offset: first coefficient, sub-interval, axis and term
   localparam int OFF_MAX     = 2046 + 14 * AXES * MAX_TERMS + AXES * MAX_TERMS;
   localparam int OFF_W       = $clog2(OFF_MAX + 1);

   localparam logic [1:0] CMD_WORD  = 2'd0;
   localparam logic [1:0] CMD_SHAPE = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] CSR_SPAN_START  = 2'd0;
   localparam logic [1:0] CSR_SPAN_END    = 2'd1;
   localparam logic [1:0] CSR_RECORD_DAYS = 2'd2;
   localparam logic [1:0] CSR_INVERSE_AU  = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic [13:0]        word_address;
      logic signed [63:0] word_value;
      logic [3:0]         body;
      logic [10:0]        first_coefficient;
      logic [4:0]         coefficient_count;
      logic [3:0]         sub_intervals;
      logic [55:0]        query_date;
   } req_type;

   typedef struct packed {
      logic signed [63:0] pos_x;
      logic signed [63:0] pos_y;
      logic signed [63:0] pos_z;
      logic               out_of_range;
   } rsp_type;

   typedef enum logic [1:0] {
      SHIFT_45,
      SHIFT_61,
      SHIFT_62
   } shift_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
      logic        neg;
      shift_type   shift;
   } mul_req_type;

endpackage

// ===== design/cep_mul.sv =====
// Shared 64x64 multiplier: four 32x32 partial products, rounding and saturation.
module cep_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  cep_pkg::mul_req_type  mul_req,
   output logic                  done,
   output logic signed [63:0]    product
);

   logic [63:0]        a_ff, b_ff;
   logic               neg_ff;
   cep_pkg::shift_type shift_ff;
   logic [127:0]       acc_ff;
   logic [2:0]         cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic signed [63:0] prod_ff;

   logic [31:0]  pa, pb;
   logic [63:0]  pp;
   logic [127:0] pp_ext;
   logic [127:0] half;
   logic         ovf;
   logic [63:0]  m;
   logic signed [63:0] final_val;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: begin pa = a_ff[31:0];  pb = b_ff[31:0];  end
         2'd1: begin pa = a_ff[31:0];  pb = b_ff[63:32]; end
         2'd2: begin pa = a_ff[63:32]; pb = b_ff[31:0];  end
         default: begin pa = a_ff[63:32]; pb = b_ff[63:32]; end
      endcase
      pp = 64'(pa) * 64'(pb);
      unique case (cnt_ff[1:0])
         2'd0: pp_ext = {64'd0, pp};
         2'd1, 2'd2: pp_ext = {32'd0, pp, 32'd0};
         default: pp_ext = {pp, 64'd0};
      endcase
   end

   always_comb begin
      unique case (mul_req.shift)
         cep_pkg::SHIFT_45: half = 128'd1 << 44;
         cep_pkg::SHIFT_61: half = 128'd1 << 60;
         cep_pkg::SHIFT_62: half = 128'd1 << 61;
         default:           half = 128'd1 << 61;
      endcase
   end

   always_comb begin
      unique case (shift_ff)
         cep_pkg::SHIFT_45: begin ovf = |acc_ff[127:109]; m = acc_ff[108:45]; end
         cep_pkg::SHIFT_61: begin ovf = |acc_ff[127:125]; m = acc_ff[124:61]; end
         cep_pkg::SHIFT_62: begin ovf = |acc_ff[127:126]; m = acc_ff[125:62]; end
         default:           begin ovf = |acc_ff[127:126]; m = acc_ff[125:62]; end
      endcase
      if (ovf) begin
         final_val = neg_ff ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end else if (neg_ff) begin
         final_val = m[63] ? 64'sh8000_0000_0000_0000 : -$signed(m);
      end else begin
         final_val = m[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(m);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            a_ff     <= mul_req.a;
            b_ff     <= mul_req.b;
            neg_ff   <= mul_req.neg;
            shift_ff <= mul_req.shift;
            acc_ff   <= half;
            cnt_ff   <= 3'd0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff == 3'd4) begin
               prod_ff <= final_val;
               done_ff <= 1'b1;
               busy_ff <= 1'b0;
            end else begin
               acc_ff <= acc_ff + pp_ext;
               cnt_ff <= cnt_ff + 3'd1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ===== design/chebyshev_ephemeris_position.sv =====
// Top level: Chebyshev ephemeris position engine with coefficient store and sequencer.
//
//  channel    ports                              handshake
//  ---------  ---------------------------------  -----------------------------------
//  request    start, busy, req_data              taken when start high and busy low
//  result     rsp_valid, rsp_data                one-cycle strobe, cannot be held off
//  config     csr_we, csr_index, csr_wdata       written when csr_we high, no wait
//
// Coefficient and shape writes leave busy low.
// A query outside the span or for a bad body is answered from the check state, out_of_range set.
// A valid query runs R record steps (one subtract per cycle), I sub-interval
// steps, the sub-interval length division (40 quotient bits), the time scaling
// division (62 quotient bits, skipped when time clamps) and n terms per axis;
// each product waits on the one shared 64x64 multiplier.
// Reset is synchronous; it clears the sequencer and the configuration registers, not the stores.
// The receiver cannot stall: each result is shown for one cycle only.
module chebyshev_ephemeris_position (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cep_pkg::req_type req_data,
   output logic             rsp_valid,
   output cep_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata
);

   localparam logic signed [63:0] Q62_POS = 64'sh4000_0000_0000_0000;
   localparam logic signed [63:0] Q62_NEG = 64'shC000_0000_0000_0000;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_REC,
      S_T0ADDR,
      S_T0WAIT,
      S_DTAU,
      S_DTDIV,
      S_ISUB,
      S_TCHK,
      S_TDIV,
      S_AXIS,
      S_MULGO,
      S_MULWAIT,
      S_ADD,
      S_SCALEGO,
      S_SCALEWAIT
   } state_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return s[63:0];
   endfunction

   function automatic logic [63:0] mag(input logic signed [63:0] a);
      return a[63] ? 64'd0 - a : a;
   endfunction

   // configuration registers
   logic [55:0] span_start_ff, span_end_ff;
   logic [7:0]  record_days_ff;
   logic [63:0] inverse_au_ff;

   // stores
   logic [63:0] mem [cep_pkg::STORE_DEPTH];
   logic [19:0] shape_ff [cep_pkg::BODY_COUNT];
   logic [cep_pkg::MEM_AW-1:0] rd_addr_ff, rd_addr_in;
   logic        zero_ff, zero_in;
   logic [63:0] mem_q_ff;

   // sequencer
   state_type state_ff;
   logic      rsp_valid_ff;
   cep_pkg::rsp_type rsp_data_ff;
   logic [3:0]  body_ff;
   logic [55:0] jd_ff;
   logic [23:0] delta_ff;
   logic [7:0]  days_ff;
   logic [cep_pkg::REC_W-1:0] rec_ff;
   logic [10:0] c_m1_ff;
   logic [4:0]  n_ff;
   logic [3:0]  g_ff;
   logic signed [63:0] dtau_ff, rem_ff;
   logic [39:0] dt_ff;
   logic [3:0]  i_ff;
   logic signed [63:0] tc_ff;
   logic        num_neg_ff;
   logic [cep_pkg::OFF_W-1:0] axis_off_ff;
   logic [1:0]  axis_ff;
   logic [4:0]  k_ff;
   logic signed [63:0] d_ff, dd_ff, tmp_ff, sum_ff;

   // shared restoring divider
   logic [40:0] div_r_ff;
   logic [63:0] div_n_ff;
   logic [63:0] div_q_ff;
   logic [39:0] div_d_ff;
   logic [5:0]  div_cnt_ff;
   logic [40:0] div_r2, div_r_in;
   logic        div_ge;
   logic [63:0] div_q_in;

   // multiplier
   cep_pkg::mul_req_type mreq;
   logic               mul_done;
   logic signed [63:0] mul_product;

   logic        accept;
   logic        bad;
   logic [19:0] shape;
   logic [10:0] sh_c;
   logic [4:0]  sh_n;
   logic [3:0]  sh_g;
   logic [4:0]  term_k;
   logic [cep_pkg::OFF_W-1:0] word;
   logic [cep_pkg::MEM_AW-1:0] rec_base;
   logic signed [41:0] num;
   logic [40:0] num_mag;
   logic signed [63:0] coef;
   logic signed [63:0] add_val;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         span_start_ff  <= 56'd0;
         span_end_ff    <= 56'd0;
         record_days_ff <= 8'd32;
         inverse_au_ff  <= 64'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            cep_pkg::CSR_SPAN_START:  span_start_ff  <= csr_wdata[55:0];
            cep_pkg::CSR_SPAN_END:    span_end_ff    <= csr_wdata[55:0];
            cep_pkg::CSR_RECORD_DAYS: record_days_ff <= csr_wdata[7:0];
            cep_pkg::CSR_INVERSE_AU:  inverse_au_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // coefficient store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (accept && req_data.command == cep_pkg::CMD_WORD &&
          req_data.word_address < cep_pkg::STORE_DEPTH) begin
         mem[cep_pkg::MEM_AW'(req_data.word_address)] <= req_data.word_value;
      end
      mem_q_ff <= mem[rd_addr_ff];
   end

   // body shape table
   always_ff @(posedge clock) begin
      if (accept && req_data.command == cep_pkg::CMD_SHAPE &&
          req_data.body < cep_pkg::BODY_COUNT) begin
         shape_ff[cep_pkg::BODY_AW'(req_data.body)] <= {req_data.sub_intervals,
                                                        req_data.coefficient_count,
                                                        req_data.first_coefficient};
      end
   end

   assign bad   = (body_ff >= cep_pkg::BODY_COUNT) || (jd_ff < span_start_ff) ||
                  (jd_ff > span_end_ff);
   assign shape = shape_ff[cep_pkg::BODY_AW'(body_ff)];
   assign sh_c  = shape[10:0];
   assign sh_n  = shape[15:11];
   assign sh_g  = shape[19:16];

   // one divider step: shift in the next dividend bit, subtract when it fits
   always_comb begin
      div_r2   = {div_r_ff[39:0], div_n_ff[63]};
      div_ge   = div_r2 >= {1'b0, div_d_ff};
      div_r_in = div_ge ? div_r2 - {1'b0, div_d_ff} : div_r2;
      div_q_in = {div_q_ff[62:0], div_ge};
   end

   // term address: record base plus axis offset plus term index (base alone in S_T0ADDR)
   always_comb begin
      rec_base = cep_pkg::MEM_AW'(int'(rec_ff) * cep_pkg::RECORD_WORDS);
      term_k   = (state_ff == S_AXIS) ? n_ff - 5'd1 : k_ff - 5'd1;
      word     = axis_off_ff + cep_pkg::OFF_W'(term_k);
      if (state_ff == S_T0ADDR) begin
         rd_addr_in = rec_base;
         zero_in    = 1'b0;
      end else begin
         rd_addr_in = rec_base + cep_pkg::MEM_AW'(word);
         zero_in    = (word >= cep_pkg::RECORD_WORDS);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_T0ADDR || state_ff == S_AXIS ||
          (state_ff == S_ADD && k_ff != 5'd0)) begin
         rd_addr_ff <= rd_addr_in;
         zero_ff    <= zero_in;
      end
   end

   always_comb begin
      num     = $signed({1'b0, rem_ff[39:0], 1'b0}) - $signed({2'b0, dt_ff});
      num_mag = num[41] ? 41'(-num) : num[40:0];
      coef    = zero_ff ? 64'sd0 : $signed(mem_q_ff);
      add_val = sat_add(tmp_ff, coef);
   end

   // multiplier operands: Clenshaw product or final AU scaling
   always_comb begin
      mreq.start = (state_ff == S_MULGO) || (state_ff == S_SCALEGO);
      if (state_ff == S_SCALEGO) begin
         mreq.a     = mag(sum_ff);
         mreq.b     = inverse_au_ff;
         mreq.neg   = sum_ff[63];
         mreq.shift = cep_pkg::SHIFT_45;
      end else begin
         mreq.a     = mag(tc_ff);
         mreq.b     = mag(d_ff);
         mreq.neg   = tc_ff[63] ^ d_ff[63];
         mreq.shift = (k_ff == 5'd0) ? cep_pkg::SHIFT_62 : cep_pkg::SHIFT_61;
      end
   end

   cep_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mreq),
      .done    (mul_done),
      .product (mul_product)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               // writes finish here; only a query leaves idle
               if (accept && req_data.command == cep_pkg::CMD_QUERY) begin
                  body_ff  <= req_data.body;
                  jd_ff    <= req_data.query_date;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (bad) begin
                  rsp_data_ff  <= '{pos_x: 64'sd0, pos_y: 64'sd0, pos_z: 64'sd0,
                                    out_of_range: 1'b1};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  delta_ff <= 24'((jd_ff - span_start_ff) >> 32);
                  days_ff  <= (record_days_ff == 8'd0) ? 8'd1 : record_days_ff;
                  rec_ff   <= '0;
                  c_m1_ff  <= (sh_c == 11'd0) ? 11'd0 : sh_c - 11'd1;
                  if (sh_n == 5'd0) begin
                     n_ff <= 5'd1;
                  end else if (sh_n > cep_pkg::MAX_TERMS) begin
                     n_ff <= 5'(cep_pkg::MAX_TERMS);
                  end else begin
                     n_ff <= sh_n;
                  end
                  g_ff     <= (sh_g == 4'd0) ? 4'd1 : sh_g;
                  rsp_data_ff.out_of_range <= 1'b0;
                  state_ff <= S_REC;
               end
            end
            S_REC: begin
               // advance one record per cycle, clamp at the last one
               if (rec_ff < cep_pkg::REC_W'(cep_pkg::RECORD_COUNT - 1) &&
                   delta_ff >= 24'(days_ff)) begin
                  delta_ff <= delta_ff - 24'(days_ff);
                  rec_ff   <= rec_ff + cep_pkg::REC_W'(1);
               end else begin
                  state_ff <= S_T0ADDR;
               end
            end
            S_T0ADDR: state_ff <= S_T0WAIT;
            S_T0WAIT: state_ff <= S_DTAU;
            S_DTAU: begin
               // record start date is word zero; start the length division
               dtau_ff    <= sat_sub($signed({8'd0, jd_ff}), $signed(mem_q_ff));
               div_r_ff   <= '0;
               div_n_ff   <= {days_ff, 56'd0};
               div_q_ff   <= '0;
               div_d_ff   <= 40'(g_ff);
               div_cnt_ff <= 6'd40;
               state_ff   <= S_DTDIV;
            end
            S_DTDIV: begin
               div_r_ff   <= div_r_in;
               div_n_ff   <= div_n_ff << 1;
               div_q_ff   <= div_q_in;
               div_cnt_ff <= div_cnt_ff - 6'd1;
               if (div_cnt_ff == 6'd1) begin
                  dt_ff    <= div_q_in[39:0];
                  rem_ff   <= dtau_ff;
                  i_ff     <= 4'd0;
                  state_ff <= S_ISUB;
               end
            end
            S_ISUB: begin
               // drop one sub-interval length per cycle, clamp at the last one
               if (i_ff < g_ff - 4'd1 && rem_ff >= $signed({24'd0, dt_ff})) begin
                  rem_ff <= rem_ff - $signed({24'd0, dt_ff});
                  i_ff   <= i_ff + 4'd1;
               end else begin
                  state_ff <= S_TCHK;
               end
            end
            S_TCHK: begin
               axis_off_ff <= cep_pkg::OFF_W'(c_m1_ff) +
                              cep_pkg::OFF_W'(i_ff) * cep_pkg::OFF_W'(n_ff) *
                              cep_pkg::OFF_W'(cep_pkg::AXES);
               axis_ff     <= 2'd0;
               if (rem_ff[63] || rem_ff == 64'sd0) begin
                  tc_ff    <= Q62_NEG;
                  state_ff <= S_AXIS;
               end else if (rem_ff >= $signed({24'd0, dt_ff})) begin
                  tc_ff    <= Q62_POS;
                  state_ff <= S_AXIS;
               end else begin
                  num_neg_ff <= num[41];
                  div_r_ff   <= num_mag;
                  div_n_ff   <= '0;
                  div_q_ff   <= '0;
                  div_d_ff   <= dt_ff;
                  div_cnt_ff <= 6'd62;
                  state_ff   <= S_TDIV;
               end
            end
            S_TDIV: begin
               div_r_ff   <= div_r_in;
               div_n_ff   <= div_n_ff << 1;
               div_q_ff   <= div_q_in;
               div_cnt_ff <= div_cnt_ff - 6'd1;
               if (div_cnt_ff == 6'd1) begin
                  tc_ff    <= num_neg_ff ? -$signed({2'b0, div_q_in[61:0]})
                                         :  $signed({2'b0, div_q_in[61:0]});
                  state_ff <= S_AXIS;
               end
            end
            S_AXIS: begin
               d_ff     <= 64'sd0;
               dd_ff    <= 64'sd0;
               k_ff     <= n_ff - 5'd1;
               state_ff <= S_MULGO;
            end
            S_MULGO: state_ff <= S_MULWAIT;
            S_MULWAIT: begin
               if (mul_done) begin
                  tmp_ff   <= sat_sub(mul_product, dd_ff);
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               if (k_ff == 5'd0) begin
                  sum_ff   <= add_val;
                  state_ff <= S_SCALEGO;
               end else begin
                  dd_ff    <= d_ff;
                  d_ff     <= add_val;
                  k_ff     <= k_ff - 5'd1;
                  state_ff <= S_MULGO;
               end
            end
            S_SCALEGO: state_ff <= S_SCALEWAIT;
            S_SCALEWAIT: begin
               if (mul_done) begin
                  unique case (axis_ff)
                     2'd0:    rsp_data_ff.pos_x <= mul_product;
                     2'd1:    rsp_data_ff.pos_y <= mul_product;
                     default: rsp_data_ff.pos_z <= mul_product;
                  endcase
                  if (axis_ff == 2'(cep_pkg::AXES - 1)) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     axis_ff     <= axis_ff + 2'd1;
                     axis_off_ff <= axis_off_ff + cep_pkg::OFF_W'(n_ff);
                     state_ff    <= S_AXIS;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/cep_checker.sv =====
// Port-level checks for the Chebyshev ephemeris position block, bound to the top level.
module cep_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input cep_pkg::req_type req_data,
   input logic             rsp_valid,
   input cep_pkg::rsp_type rsp_data
);

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.command == cep_pkg::CMD_QUERY |=> busy)
      else $error("query taken but block not busy");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.command != cep_pkg::CMD_QUERY |=> !busy)
      else $error("write left block busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result without a query in flight");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |->
         rsp_data.pos_x == 64'sd0 && rsp_data.pos_y == 64'sd0 && rsp_data.pos_z == 64'sd0)
      else $error("out of range result with nonzero position");

endmodule

bind chebyshev_ephemeris_position cep_checker u_cep_checker (.*);
